>>> rtl/core/rmq_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared definitions
// Fixed-point formats, derived datapath widths and the sideband word type.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Fraction bits of the Q1.16 format on every port; 1.0 is 2^FRAC_BITS.
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 18;
    localparam int OUT_W     = 18;
    localparam int LANES     = 4;

    // Raw components are sums of up to three entries and the constant one.
    localparam int CW        = IN_W + 2;
    localparam int MAG_W     = CW - 1;
    localparam int N4_W      = CW - 1;

    // Radicand n4 * 2^FRAC_BITS, rounded up to an even width for the root.
    localparam int RAD_W     = 2 * ((N4_W + FRAC_BITS + 1) / 2);
    localparam int ROOT_W    = RAD_W / 2;

    // Divider: denominator 2*s, quotient saturates at 1.0.
    localparam int DEN_W     = ROOT_W + 1;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int NUM_W     = DEN_W + Q_W;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

    // Per-word sideband carried alongside the arithmetic.
    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             bad;
    } t_side;

endpackage

>>> rtl/core/rmq_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
module rmq_isqrt
    import rmq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 3;

    logic              r_vld  [0:ROOT_W];
    logic [RAD_W-1:0]  r_rad  [0:ROOT_W];
    logic [REM_W-1:0]  r_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] r_root [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        r_rad[0]  <= i_rad;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;

        assign rem_sh = {r_rem[k][REM_W-3:0], r_rad[k][RAD_W-1 -: 2]};
        assign trial  = REM_W'({r_root[k], 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rad[k+1] <= r_rad[k] << 2;
            if (rem_sh >= trial) begin
                r_rem[k+1]  <= rem_sh - trial;
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                r_rem[k+1]  <= rem_sh;
                r_root[k+1] <= {r_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W];
    assign o_root = r_root[ROOT_W];

endmodule

>>> rtl/core/rmq_div.sv
// ----------------------------------------------------------------------------
// Pipelined saturating divider lane
// Restoring division, one quotient bit per stage, result clamped to 1.0.
// ----------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
(
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    logic [DEN_W-1:0] r_rem [0:Q_W];
    logic [Q_W-1:0]   r_low [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic [Q_W-1:0]   r_quo [0:Q_W];
    logic             r_ovf [0:Q_W];
    logic [Q_W-1:0]   r_res;

    // When the high part already reaches the divisor the quotient exceeds
    // the quotient width and the result saturates.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num[NUM_W-1:Q_W];
        r_low[0] <= i_num[Q_W-1:0];
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_ovf[0] <= (i_num[NUM_W-1:Q_W] >= i_den);
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DEN_W:0] rem_sh;

        assign rem_sh = {r_rem[k], r_low[k][Q_W-1]};

        always_ff @(posedge i_clk) begin
            r_low[k+1] <= r_low[k] << 1;
            r_den[k+1] <= r_den[k];
            r_ovf[k+1] <= r_ovf[k];
            if (rem_sh >= {1'b0, r_den[k]}) begin
                r_rem[k+1] <= DEN_W'(rem_sh - {1'b0, r_den[k]});
                r_quo[k+1] <= {r_quo[k][Q_W-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= DEN_W'(rem_sh);
                r_quo[k+1] <= {r_quo[k][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ovf[Q_W] || (r_quo[Q_W] > Q_ONE)) begin
            r_res <= Q_ONE;
        end else begin
            r_res <= r_quo[Q_W];
        end
    end

    assign o_quo = r_res;

endmodule

>>> rtl/core/rotation_matrix_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion core
// Shepperd's method in Q1.16: branch select, square root, four divisions.
// ----------------------------------------------------------------------------
// Usage: present the nine matrix entries on i_m00..i_m22 and pulse start.
// A word is taken at every clock edge where start is high and busy is low.
// The core is fully pipelined, so busy is always low and a new matrix may
// be started in every cycle. Throughput is one word per clock.
// Each result appears on o_quat_x/y/z/w and o_bad_input for exactly one
// cycle, flagged by o_valid.
// The word passes 41 register stages: branch select, the root input plus
// one stage per bit of the 18-bit square root, the division operands, the
// divider input plus one stage per bit of the 17-bit quotient and the clamp,
// and the output register.
// The receiver cannot stall the core; results are simply presented, and
// results of back-to-back words come out on consecutive cycles.
// When the pivot value is not positive the matrix is not a rotation: all
// four components read zero and o_bad_input is set.
// Synchronous reset clears every valid bit, so nothing in flight is
// delivered after reset; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core
    import rmq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  i_m00,
    input  logic signed [IN_W-1:0]  i_m01,
    input  logic signed [IN_W-1:0]  i_m02,
    input  logic signed [IN_W-1:0]  i_m10,
    input  logic signed [IN_W-1:0]  i_m11,
    input  logic signed [IN_W-1:0]  i_m12,
    input  logic signed [IN_W-1:0]  i_m20,
    input  logic signed [IN_W-1:0]  i_m21,
    input  logic signed [IN_W-1:0]  i_m22,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_quat_x,
    output logic signed [OUT_W-1:0] o_quat_y,
    output logic signed [OUT_W-1:0] o_quat_z,
    output logic signed [OUT_W-1:0] o_quat_w,
    output logic                    o_bad_input
);

    localparam logic signed [CW-1:0] C_ONE = CW'(1) <<< FRAC_BITS;
    localparam int DLY_W = Q_W + 2;

    // The pipeline never holds off a new word.
    assign busy = 1'b0;

    // ---------------------------------------------------------------
    // Stage A: trace, branch choice and the four raw components.
    // ---------------------------------------------------------------
    logic signed [CW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [CW-1:0] tr;
    logic signed [CW-1:0] n_c [0:LANES-1];
    logic signed [CW-1:0] n_n4;

    assign a00 = CW'(i_m00);
    assign a01 = CW'(i_m01);
    assign a02 = CW'(i_m02);
    assign a10 = CW'(i_m10);
    assign a11 = CW'(i_m11);
    assign a12 = CW'(i_m12);
    assign a20 = CW'(i_m20);
    assign a21 = CW'(i_m21);
    assign a22 = CW'(i_m22);
    assign tr  = a00 + a11 + a22;

    // Positive trace uses w as pivot; otherwise the largest diagonal entry
    // picks the pivot, with ties going to the later entry.
    always_comb begin
        if (tr > 0) begin
            n_c[0] = a12 - a21;
            n_c[1] = a20 - a02;
            n_c[2] = a01 - a10;
            n_c[3] = tr + C_ONE;
            n_n4   = n_c[3];
        end else if ((a00 > a11) && (a00 > a22)) begin
            n_c[0] = C_ONE + a00 - a11 - a22;
            n_c[1] = a10 + a01;
            n_c[2] = a20 + a02;
            n_c[3] = a12 - a21;
            n_n4   = n_c[0];
        end else if (a11 > a22) begin
            n_c[0] = a10 + a01;
            n_c[1] = C_ONE + a11 - a00 - a22;
            n_c[2] = a21 + a12;
            n_c[3] = a20 - a02;
            n_n4   = n_c[1];
        end else begin
            n_c[0] = a20 + a02;
            n_c[1] = a21 + a12;
            n_c[2] = C_ONE + a22 - a00 - a11;
            n_c[3] = a01 - a10;
            n_n4   = n_c[2];
        end
    end

    logic                 r_a_vld;
    logic signed [CW-1:0] r_a_c [0:LANES-1];
    logic signed [CW-1:0] r_a_n4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
        r_a_c  <= n_c;
        r_a_n4 <= n_n4;
    end

    // ---------------------------------------------------------------
    // Stage B: square root of n4 * 2^FRAC_BITS, with component magnitudes
    // and signs delayed alongside it.
    // ---------------------------------------------------------------
    logic [RAD_W-1:0]  sq_rad;
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;

    assign sq_rad = RAD_W'({r_a_n4[N4_W-1:0], {FRAC_BITS{1'b0}}});

    rmq_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_a_vld),
        .i_rad   (sq_rad),
        .o_vld   (sq_vld),
        .o_root  (sq_root)
    );

    logic [MAG_W-1:0] r_b_mag  [0:ROOT_W][0:LANES-1];
    t_side            r_b_side [0:ROOT_W];

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_b_mag[0][l]     <= r_a_c[l][CW-1] ? MAG_W'(-r_a_c[l])
                                                : MAG_W'(r_a_c[l]);
            r_b_side[0].neg[l] <= r_a_c[l][CW-1];
        end
        r_b_side[0].bad <= !(r_a_n4 > 0);
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_bdly
        always_ff @(posedge i_clk) begin
            r_b_mag[k+1]  <= r_b_mag[k];
            r_b_side[k+1] <= r_b_side[k];
        end
    end

    // ---------------------------------------------------------------
    // Stage C: division operands. Numerator |q| * 2^FRAC_BITS + s for
    // round-half-up, denominator 2 * s.
    // ---------------------------------------------------------------
    logic             r_c_vld;
    logic [NUM_W-1:0] r_c_num [0:LANES-1];
    logic [DEN_W-1:0] r_c_den;
    t_side            r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= sq_vld;
        end
        for (int l = 0; l < LANES; l++) begin
            r_c_num[l] <= NUM_W'({r_b_mag[ROOT_W][l], {FRAC_BITS{1'b0}}})
                          + NUM_W'(sq_root);
        end
        r_c_den  <= {sq_root, 1'b0};
        r_c_side <= r_b_side[ROOT_W];
    end

    // ---------------------------------------------------------------
    // Stage D: four divider lanes, valid and sideband delayed to match.
    // ---------------------------------------------------------------
    logic [Q_W-1:0] d_quo [0:LANES-1];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        rmq_div u_div (
            .i_clk (i_clk),
            .i_num (r_c_num[l]),
            .i_den (r_c_den),
            .o_quo (d_quo[l])
        );
    end

    logic  r_d_vld  [0:DLY_W-1];
    t_side r_d_side [0:DLY_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else begin
            r_d_vld[0] <= r_c_vld;
        end
        r_d_side[0] <= r_c_side;
    end

    for (genvar k = 1; k < DLY_W; k++) begin : g_ddly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[k] <= 1'b0;
            end else begin
                r_d_vld[k] <= r_d_vld[k-1];
            end
            r_d_side[k] <= r_d_side[k-1];
        end
    end

    // ---------------------------------------------------------------
    // Output register: restore signs, force zero on a bad pivot.
    // ---------------------------------------------------------------
    logic             r_o_vld;
    logic [OUT_W-1:0] r_o_q [0:LANES-1];
    logic             r_o_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_d_vld[DLY_W-1];
        end
        for (int l = 0; l < LANES; l++) begin
            if (r_d_side[DLY_W-1].bad) begin
                r_o_q[l] <= '0;
            end else if (r_d_side[DLY_W-1].neg[l]) begin
                r_o_q[l] <= OUT_W'(-OUT_W'(d_quo[l]));
            end else begin
                r_o_q[l] <= OUT_W'(d_quo[l]);
            end
        end
        r_o_bad <= r_d_side[DLY_W-1].bad;
    end

    assign o_valid     = r_o_vld;
    assign o_quat_x    = r_o_q[0];
    assign o_quat_y    = r_o_q[1];
    assign o_quat_z    = r_o_q[2];
    assign o_quat_w    = r_o_q[3];
    assign o_bad_input = r_o_bad;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion core testbench
// Drives matrices through the start/busy handshake and checks every result
// word against a built-in fixed-point predictor of the conversion.
// ----------------------------------------------------------------------------
module testbench;
    import rmq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;
    localparam int ONE         = 1 << FRAC_BITS;

    // Matrix entry constants at the field width.
    localparam logic signed [IN_W-1:0] S_ZERO = '0;
    localparam logic signed [IN_W-1:0] S_P1   = IN_W'(ONE);
    localparam logic signed [IN_W-1:0] S_N1   = IN_W'(-ONE);
    localparam logic signed [IN_W-1:0] S_LSB  = IN_W'(1);
    localparam logic signed [IN_W-1:0] S_NLSB = IN_W'(-1);
    localparam logic signed [IN_W-1:0] S_MAX  = IN_W'(131071);
    localparam logic signed [IN_W-1:0] S_MIN  = IN_W'(-131072);

    typedef struct {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        logic [OUT_W-1:0] z;
        logic [OUT_W-1:0] w;
        logic             bad;
    } t_quat;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic signed [IN_W-1:0]  i_m [9];
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_quat_x, o_quat_y, o_quat_z, o_quat_w;
    logic                    o_bad_input;

    t_quat quat_queue[$];
    int    mismatches = 0;
    int    cycles = 0;
    int    words_sent = 0;
    int    words_checked = 0;
    int    bad_seen = 0;
    bit    no_idle = 1'b0;

    initial foreach (i_m[k]) i_m[k] = '0;

    always #1 i_clk = ~i_clk;

    rotation_matrix_to_quaternion_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_m00       (i_m[0]),
        .i_m01       (i_m[1]),
        .i_m02       (i_m[2]),
        .i_m10       (i_m[3]),
        .i_m11       (i_m[4]),
        .i_m12       (i_m[5]),
        .i_m20       (i_m[6]),
        .i_m21       (i_m[7]),
        .i_m22       (i_m[8]),
        .o_valid     (o_valid),
        .o_quat_x    (o_quat_x),
        .o_quat_y    (o_quat_y),
        .o_quat_z    (o_quat_z),
        .o_quat_w    (o_quat_w),
        .o_bad_input (o_bad_input)
    );

    // Exact integer square root, one result bit settled per step.
    function automatic longint unsigned int_sqrt(input longint unsigned radicand);
        longint unsigned rest;
        longint unsigned root;
        longint unsigned probe;
        rest  = radicand;
        root  = 0;
        probe = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Scales one raw component by 0.5/root with round half away from zero,
    // then saturates the magnitude to 1.0 and restores the sign.
    function automatic logic [OUT_W-1:0] scale_component(input longint raw,
                                                         input longint unsigned root);
        longint unsigned mag;
        longint unsigned quo;
        mag = (raw < 0) ? longint'(-raw) : longint'(raw);
        quo = ((mag << FRAC_BITS) + root) / (2 * root);
        if (quo > ONE) quo = ONE;
        return (raw < 0) ? OUT_W'(-longint'(quo)) : OUT_W'(quo);
    endfunction

    // Shepperd's method: trace branch when the trace is positive, otherwise
    // the branch of the largest diagonal entry, ties going to the later one.
    function automatic t_quat predict_quat(input logic signed [IN_W-1:0] m [9]);
        longint e [9];
        longint tr, pivot;
        longint comp [4];
        longint unsigned root;
        t_quat  q;
        foreach (e[k]) e[k] = longint'(m[k]);
        tr = e[0] + e[4] + e[8];
        if (tr > 0) begin
            comp[0] = e[5] - e[7];
            comp[1] = e[6] - e[2];
            comp[2] = e[1] - e[3];
            comp[3] = tr + ONE;
            pivot   = comp[3];
        end else if (e[0] > e[4] && e[0] > e[8]) begin
            comp[0] = ONE + e[0] - e[4] - e[8];
            comp[1] = e[3] + e[1];
            comp[2] = e[6] + e[2];
            comp[3] = e[5] - e[7];
            pivot   = comp[0];
        end else if (e[4] > e[8]) begin
            comp[0] = e[3] + e[1];
            comp[1] = ONE + e[4] - e[0] - e[8];
            comp[2] = e[7] + e[5];
            comp[3] = e[6] - e[2];
            pivot   = comp[1];
        end else begin
            comp[0] = e[6] + e[2];
            comp[1] = e[7] + e[5];
            comp[2] = ONE + e[8] - e[0] - e[4];
            comp[3] = e[1] - e[3];
            pivot   = comp[2];
        end
        if (pivot <= 0) begin
            q = '{x: '0, y: '0, z: '0, w: '0, bad: 1'b1};
        end else begin
            root  = int_sqrt(longint'(pivot) << FRAC_BITS);
            q.x   = scale_component(comp[0], root);
            q.y   = scale_component(comp[1], root);
            q.z   = scale_component(comp[2], root);
            q.w   = scale_component(comp[3], root);
            q.bad = 1'b0;
        end
        return q;
    endfunction

    // Presents one matrix, waits for the core to take it, and logs the
    // expected quaternion. Start stays high into the next word unless a
    // random idle gap follows.
    task automatic send_matrix(input logic signed [IN_W-1:0] m [9]);
        int gap;
        foreach (i_m[k]) i_m[k] = m[k];
        start = 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        quat_queue.insert(quat_queue.size(), predict_quat(m));
        words_sent++;
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 99) < 13) begin
            start = 1'b0;
            foreach (i_m[k]) i_m[k] = IN_W'($urandom);
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic int q16(input real v);
        return $rtoi(v * ONE);
    endfunction

    // Builds a proper rotation matrix from a random quaternion.
    task automatic send_rotation(input bit small_w);
        real qx, qy, qz, qw, n;
        logic signed [IN_W-1:0] m [9];
        qx = real'($urandom_range(0, 2000)) - 1000.0;
        qy = real'($urandom_range(0, 2000)) - 1000.0;
        qz = real'($urandom_range(0, 2000)) - 1000.0;
        qw = small_w ? real'($urandom_range(0, 100)) - 50.0
                     : real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(qx*qx + qy*qy + qz*qz + qw*qw);
        if (n < 1.0) begin
            qw = 1.0;
            n  = 1.0;
        end
        qx = qx / n; qy = qy / n; qz = qz / n; qw = qw / n;
        m[0] = IN_W'(q16(1.0 - 2.0*(qy*qy + qz*qz)));
        m[1] = IN_W'(q16(2.0*(qx*qy - qz*qw)));
        m[2] = IN_W'(q16(2.0*(qx*qz + qy*qw)));
        m[3] = IN_W'(q16(2.0*(qx*qy + qz*qw)));
        m[4] = IN_W'(q16(1.0 - 2.0*(qx*qx + qz*qz)));
        m[5] = IN_W'(q16(2.0*(qy*qz - qx*qw)));
        m[6] = IN_W'(q16(2.0*(qx*qz - qy*qw)));
        m[7] = IN_W'(q16(2.0*(qy*qz + qx*qw)));
        m[8] = IN_W'(q16(1.0 - 2.0*(qx*qx + qy*qy)));
        send_matrix(m);
    endtask

    // Identity, half turns about each axis (every branch), quarter turns about z,
    // the zero matrix, ties on the diagonal, saturating components and the field extremes.
    task automatic test_directed();
        logic signed [IN_W-1:0] m [9];
        m = '{S_P1, S_ZERO, S_ZERO, S_ZERO, S_P1, S_ZERO, S_ZERO, S_ZERO, S_P1};
        send_matrix(m);
        m = '{S_P1, S_ZERO, S_ZERO, S_ZERO, S_N1, S_ZERO, S_ZERO, S_ZERO, S_N1};
        send_matrix(m);
        m = '{S_N1, S_ZERO, S_ZERO, S_ZERO, S_P1, S_ZERO, S_ZERO, S_ZERO, S_N1};
        send_matrix(m);
        m = '{S_N1, S_ZERO, S_ZERO, S_ZERO, S_N1, S_ZERO, S_ZERO, S_ZERO, S_P1};
        send_matrix(m);
        m = '{S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO};
        send_matrix(m);
        m = '{S_N1, S_ZERO, S_ZERO, S_ZERO, S_N1, S_ZERO, S_ZERO, S_ZERO, S_N1};
        send_matrix(m);
        m = '{S_ZERO, S_N1, S_ZERO, S_P1, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_P1};
        send_matrix(m);
        m = '{S_ZERO, S_P1, S_ZERO, S_N1, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_P1};
        send_matrix(m);
        m = '{S_LSB, S_P1, S_P1, S_N1, S_LSB, S_P1, S_N1, S_N1, S_NLSB};
        send_matrix(m);
        m = '{S_N1, S_P1, S_P1, S_P1, S_N1, S_P1, S_P1, S_P1, S_N1};
        send_matrix(m);
        m = '{S_N1, S_N1, S_N1, S_N1, S_ZERO, S_N1, S_N1, S_N1, S_N1};
        send_matrix(m);
        m = '{S_P1, S_ZERO, S_ZERO, S_ZERO, S_P1, S_ZERO, S_ZERO, S_ZERO, S_ZERO};
        send_matrix(m);
        // Entries beyond +-1.0, including the most negative 18-bit value.
        m = '{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN};
        send_matrix(m);
        m = '{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX};
        send_matrix(m);
        m = '{S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MIN};
        send_matrix(m);
        m = '{S_LSB, S_NLSB, S_LSB, S_NLSB, S_ZERO, S_LSB, S_NLSB, S_LSB, S_ZERO};
        send_matrix(m);
    endtask

    // Well-formed rotations with random axes; a share of them has a small
    // real part so the non-trace branches get plenty of traffic.
    task automatic test_rotations(input int count);
        for (int k = 0; k < count; k++) begin
            no_idle = (k >= count / 2) && (k < count / 2 + 150);
            send_rotation($urandom_range(0, 2) == 0);
        end
        no_idle = 1'b0;
    endtask

    // Arbitrary matrices: mostly inside +-1.0, some across the full field.
    task automatic test_noise(input int count);
        logic signed [IN_W-1:0] m [9];
        for (int k = 0; k < count; k++) begin
            foreach (m[j]) begin
                if ($urandom_range(0, 3) == 0) m[j] = IN_W'($urandom);
                else m[j] = IN_W'($urandom_range(0, 2 * ONE) - ONE);
            end
            send_matrix(m);
        end
    endtask

    // Checks every result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_quat exp_q;
        if (i_rst_n && o_valid) begin
            if (quat_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word at cycle %0d", cycles);
            end else begin
                exp_q = quat_queue.pop_front();
                words_checked++;
                if (o_bad_input) bad_seen++;
                if (o_quat_x !== exp_q.x || o_quat_y !== exp_q.y ||
                    o_quat_z !== exp_q.z || o_quat_w !== exp_q.w ||
                    o_bad_input !== exp_q.bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("ERROR: word %0d expected x=%h y=%h z=%h w=%h bad=%b",
                               words_checked, exp_q.x, exp_q.y, exp_q.z, exp_q.w,
                               exp_q.bad);
                        $display(" got x=%h y=%h z=%h w=%h bad=%b",
                                 o_quat_x, o_quat_y, o_quat_z, o_quat_w, o_bad_input);
                    end
                end
            end
        end
    end

    // Watchdog for a hung core or a lost handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycles, quat_queue.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_rotations(900);
        test_noise(340);
        start = 1'b0;
        while (quat_queue.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (mismatches > 10)
            $display("%0d further mismatches not shown", mismatches - 10);
        $display("Sent %0d matrices (directed, rotations, arbitrary), checked %0d words,",
                 words_sent, words_checked);
        $display("%0d flagged as not a rotation, %0d mismatches", bad_seen, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> rotation_matrix_to_quaternion_core.f
rtl/core/rmq_pkg.sv
rtl/core/rmq_isqrt.sv
rtl/core/rmq_div.sv
rtl/core/rotation_matrix_to_quaternion_core.sv
test/testbench.sv
